### src/assert_macros.svh
// Assertion macros for the checker file of the RTL folder.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### src/pffa_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the priority first-fit allocator.
// No dependencies.
package pffa_pkg;

  localparam int MAX_HOSTS_DEF = 16;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_ALLOC   = 2'd2,
    ST_NOALLOC = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_INSERT = 6'b000100,
    S_SCAN   = 6'b001000,
    S_BUBBLE = 6'b010000,
    S_DONE   = 6'b100000
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  ident;
    logic [1:0]  level;
    logic [15:0] free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic        command;
    logic [7:0]  item_id;
    logic [1:0]  priority_req;
    logic [15:0] amount;
    logic        allow_lower;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  request_id;
    logic [7:0]  host_id;
    logic [15:0] remaining;
  } res_t;

endpackage

### src/pffa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/pffa_seq.sv
`timescale 1ns / 1ps
// Sequencer of the allocator: host table walk for insert, first-fit scan and bubble-down.
// Depends on pffa_pkg and pffa_ram.
module pffa_seq #(
  parameter int MAX_HOSTS = pffa_pkg::MAX_HOSTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_valid,
  output logic            req_ready,
  input  pffa_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_ready,
  output pffa_pkg::res_t  res
);
  import pffa_pkg::*;

  localparam int AW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam int CW = $clog2(MAX_HOSTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_HOSTS);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  seq_state_t    state_r, state_nxt;
  req_t          req_r, req_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  entry_t        ent_r, ent_nxt;
  logic          started_r, started_nxt;
  res_t          res_r, res_nxt;

  logic [CW-1:0] cnt_m1, idx_m1, idx_m2, idx_p1, idx_p2;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;
  logic [15:0]   alu_b;
  logic [16:0]   alu_diff;
  logic          borrow;
  logic          ins_before;
  logic          in_range;

  pffa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_HOSTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cnt_m1 = cnt_r - ONE;
  assign idx_m1 = idx_r - ONE;
  assign idx_m2 = idx_r - TWO;
  assign idx_p1 = idx_r + ONE;
  assign idx_p2 = idx_r + TWO;

  // Shared subtract/compare unit: table capacity minus demand or moving capacity.
  assign alu_b    = state_r == S_BUBBLE ? ent_r.free : req_r.amount;
  assign alu_diff = {1'b0, rd_data.free} - {1'b0, alu_b};
  assign borrow   = alu_diff[16];

  // New host sorts strictly ahead of the table entry just read.
  assign ins_before = (req_r.priority_req != rd_data.level) ?
                      (req_r.priority_req > rd_data.level) : borrow;
  assign in_range   = started_r || (rd_data.level <= req_r.priority_req);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    ent_nxt     = ent_r;
    started_nxt = started_r;
    res_nxt     = res_r;
    rd_addr     = idx_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_r[AW-1:0];
    wr_data     = ent_r;
    req_ready   = 1'b0;
    res_valid   = 1'b0;
    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt   = req;
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_nxt     = '{status: ST_LOADED, request_id: req_r.item_id,
                        host_id: 8'd0, remaining: 16'd0};
        started_nxt = 1'b0;
        if (req_r.command == CMD_LOAD) begin
          if (cnt_r == CNT_MAX) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt   = cnt_r;
            rd_addr   = cnt_m1[AW-1:0];
            state_nxt = S_INSERT;
          end
        end else begin
          idx_nxt   = '0;
          rd_addr   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_INSERT: begin
        wr_en = 1'b1;
        if (idx_r != '0 && ins_before) begin
          // shift the entry above one slot down and look one further up
          wr_data = rd_data;
          idx_nxt = idx_m1;
          rd_addr = idx_m2[AW-1:0];
        end else begin
          wr_data   = '{ident: req_r.item_id, level: req_r.priority_req,
                        free: req_r.amount};
          cnt_nxt   = cnt_r + ONE;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (idx_r == cnt_r) begin
          res_nxt.status = ST_NOALLOC;
          state_nxt      = S_DONE;
        end else if (!in_range) begin
          idx_nxt = idx_p1;
          rd_addr = idx_p1[AW-1:0];
        end else if (rd_data.level < req_r.priority_req && !req_r.allow_lower) begin
          res_nxt.status = ST_NOALLOC;
          state_nxt      = S_DONE;
        end else if (!borrow) begin
          ent_nxt           = '{ident: rd_data.ident, level: rd_data.level,
                                free: alu_diff[15:0]};
          res_nxt.status    = ST_ALLOC;
          res_nxt.host_id   = rd_data.ident;
          res_nxt.remaining = alu_diff[15:0];
          rd_addr           = idx_p1[AW-1:0];
          state_nxt         = S_BUBBLE;
        end else begin
          started_nxt = 1'b1;
          idx_nxt     = idx_p1;
          rd_addr     = idx_p1[AW-1:0];
        end
      end
      S_BUBBLE: begin
        wr_en = 1'b1;
        if (idx_p1 == cnt_r || rd_data.level < ent_r.level || borrow) begin
          wr_data   = ent_r;
          state_nxt = S_DONE;
        end else begin
          // next entry moves up, chosen host keeps sinking
          wr_data = rd_data;
          idx_nxt = idx_p1;
          rd_addr = idx_p2[AW-1:0];
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    ent_r     <= ent_nxt;
    started_r <= started_nxt;
    res_r     <= res_nxt;
  end

  assign res = res_r;

endmodule

### src/priority_first_fit_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the priority first-fit allocator: stream ports and output register.
// Depends on pffa_pkg and pffa_seq.
//
// Usage:
//   Input stream in_*: one transfer is a load (in_tuser = 0, host id, level and
//   capacity) or an allocate request (in_tuser = 1, request id, priority, demand,
//   allow-lower flag). Each input transfer gives exactly one output transfer on
//   out_*: out_tuser carries the status, out_tdata the echoed id, the chosen host
//   and its remaining capacity (zero unless the status is allocated).
//   Flow: items are handled one at a time; in_tready is low from the accepted
//   transfer until its result enters the output register. The host table sits in
//   a RAM with one read port and registered read, walked one entry per cycle:
//   a load goes from the start state through insert steps to done, an allocate
//   from start through scan and bubble-down steps to done, and the sequencer
//   returns to idle before it accepts the next item.
//   The next item is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the finished result waits inside
//   the sequencer and the input stays stalled.
//   Reset empties the host table (count to zero) and drops any pending result;
//   table contents need no clearing.
module priority_first_fit_allocator_top #(
  parameter int MAX_HOSTS = pffa_pkg::MAX_HOSTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // item_id[7:0], priority_req[9:8], amount[25:10], allow_lower[26], zero fill
  input  logic [pffa_pkg::IN_TDATA_W-1:0]     in_tdata,
  // command[0]
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // request_id[7:0], allocated_host_id[15:8], remaining_capacity[31:16]
  output logic [pffa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status[1:0]
  output logic [1:0]                          out_tuser
);
  import pffa_pkg::*;

  req_t req;
  res_t res;
  logic res_valid, res_ready;
  logic out_valid_r;
  res_t out_r;

  assign req = '{command: in_tuser[0], item_id: in_tdata[7:0],
                 priority_req: in_tdata[9:8], amount: in_tdata[25:10],
                 allow_lower: in_tdata[26]};

  pffa_seq #(
    .MAX_HOSTS (MAX_HOSTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {out_r.remaining, out_r.host_id, out_r.request_id};

endmodule

### src/pffa_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the allocator top, attached by bind.
// Depends on pffa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pffa_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [pffa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [1:0]                        out_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready
);
  import pffa_pkg::*;

  // stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // host id and capacity are zero unless allocated
  `ASSERT_CLK(a_zero_fields, clk, rst_n, out_tvalid && out_tuser != ST_ALLOC |-> out_tdata[31:8] == 24'd0)

  // one item in flight: busy right after an accepted transfer
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)

  // reset drops the pending result
  `ASSERT_NORST(a_reset_clears, clk, !rst_n |=> !out_tvalid)

endmodule

bind priority_first_fit_allocator_top pffa_chk u_pffa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
